FILE: rtl/pmc_pkg.sv
// Package for the pointer motion coalescer: event record type, register
// indexes and fixed widths shared by the coalescer RTL.
// No dependencies.
`timescale 1ns / 1ps

package pmc_pkg;

  localparam int unsigned TypeW   = 16;
  localparam int unsigned CodeW   = 16;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned ExtraW  = 32;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned DataW   = TypeW + CodeW + ValueW + ExtraW + TimeW;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  // Burst counter is wide enough for the largest allowed burst length
  localparam int unsigned CountW       = 7;
  localparam int unsigned BurstLenDflt = 64;

  // Totals must stay inside the 16-bit signed range
  localparam logic signed [ValueW:0] SumMax = 33'sd32767;
  localparam logic signed [ValueW:0] SumMin = -33'sd32768;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_MOVE_TYPE = 2'd0,
    REG_REL_TYPE  = 2'd1,
    REG_AXIS_X    = 2'd2,
    REG_AXIS_Y    = 2'd3
  } cfg_reg_t;

  // One result event as held in the output queue
  typedef struct packed {
    logic [TypeW-1:0]         ev_type;
    logic [CodeW-1:0]         ev_code;
    logic signed [ValueW-1:0] ev_value;
    logic [ExtraW-1:0]        ev_extra;
    logic [TimeW-1:0]         ev_time;
    logic                     last;
  } evt_t;

endpackage

FILE: rtl/pointer_motion_coalescer.sv
// Pointer motion coalescer top level: input register, single-pass merge
// logic, two-entry result queue. Depends on pmc_pkg.
//
// An input passes the input register and then the result queue on its way to out_tdata.
// Throughput: one input per cycle when each input gives at most one result and
// out_tready does not stall; an input giving two results waits for room for both,
// set by the single result port draining the two-entry result queue.
// Reset (rst_n low, synchronous): totals, motion time and burst count clear,
// registers return to move 0, relative 1, axis X 0, axis Y 1; queue empties.
`timescale 1ns / 1ps

module pointer_motion_coalescer
  import pmc_pkg::*;
#(
  parameter int unsigned BURST_LEN = BurstLenDflt
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input events
  input  logic                in_tvalid,
  output logic                in_tready,
  // [15:0] event_type, [31:16] event_code, [63:32] event_value,
  // [95:64] event_extra, [159:96] event_time
  input  logic [DataW-1:0]    in_tdata,
  input  logic                in_tlast,   // queue_empty
  // Result events
  output logic                out_tvalid,
  input  logic                out_tready,
  // [15:0] out_type, [31:16] out_code, [63:32] out_value,
  // [95:64] out_extra, [159:96] out_time
  output logic [DataW-1:0]    out_tdata,
  output logic                out_tlast,  // last result of this input
  // Configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgW-1:0]     cfg_data
);

  // Configuration registers
  logic [TypeW-1:0] move_code_r, rel_code_r;
  logic [CodeW-1:0] axis_x_r, axis_y_r;

  // Input register
  logic                     inv_r;
  logic [TypeW-1:0]         in_type_r;
  logic [CodeW-1:0]         in_code_r;
  logic signed [ValueW-1:0] in_value_r;
  logic [ExtraW-1:0]        in_extra_r;
  logic [TimeW-1:0]         in_time_r;
  logic                     in_qempty_r;

  // Coalescing state
  logic signed [ValueW-1:0] sum_x_r, sum_y_r, sum_x_nxt, sum_y_nxt;
  logic [TimeW-1:0]         mtime_r, mtime_nxt;
  logic [CountW-1:0]        burst_r, burst_nxt;

  // Result queue, head in entry 0
  evt_t       q_r [2];
  evt_t       q_nxt [2];
  logic [1:0] cnt_r, cnt_nxt;

  // Merge datapath
  logic                     is_move, is_rel, motion_hit;
  logic signed [ValueW-1:0] ax, ay, new_x, new_y;
  logic signed [ValueW:0]   nx, ny;
  logic                     ovf, pend, emit_old, emit_new, burst_end;
  logic [CountW:0]          burst_inc;
  logic [1:0]               nres;
  logic [1:0]               free;
  logic                     pop, proc;
  evt_t                     old_ev, pass_ev, new_ev, res0, res1;
  logic [1:0]               base;

  assign cfg_ready = 1'b1;

  // Configuration write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_code_r <= '0;
      rel_code_r  <= TypeW'(1);
      axis_x_r    <= '0;
      axis_y_r    <= CodeW'(1);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MOVE_TYPE: move_code_r <= cfg_data;
        REG_REL_TYPE:  rel_code_r  <= cfg_data;
        REG_AXIS_X:    axis_x_r    <= cfg_data;
        REG_AXIS_Y:    axis_y_r    <= cfg_data;
        default:       ;
      endcase
    end
  end

  // Event classification and axis deltas
  always_comb begin
    is_move    = (in_type_r == move_code_r);
    is_rel     = !is_move && (in_type_r == rel_code_r);
    motion_hit = is_move || is_rel;
    ax = '0;
    ay = '0;
    if (is_move) begin
      ax = in_value_r;
      ay = $signed(in_extra_r);
    end else if (is_rel) begin
      if (in_code_r == axis_x_r) ax = in_value_r;
      else if (in_code_r == axis_y_r) ay = in_value_r;
    end
  end

  // Trial sums and range check
  assign nx   = {sum_x_r[ValueW-1], sum_x_r} + {ax[ValueW-1], ax};
  assign ny   = {sum_y_r[ValueW-1], sum_y_r} + {ay[ValueW-1], ay};
  assign ovf  = motion_hit && (nx > SumMax || nx < SumMin || ny > SumMax || ny < SumMin);
  assign pend = (sum_x_r != '0) || (sum_y_r != '0);
  assign emit_old = pend && (ovf || !motion_hit);

  // Totals after this event, before any end-of-burst flush
  always_comb begin
    if (!motion_hit) begin
      new_x = '0;
      new_y = '0;
    end else if (ovf) begin
      new_x = ax;
      new_y = ay;
    end else begin
      new_x = nx[ValueW-1:0];
      new_y = ny[ValueW-1:0];
    end
  end

  // End of burst
  assign burst_inc = {1'b0, burst_r} + (CountW+1)'(1);
  assign burst_end = in_qempty_r || (burst_inc >= (CountW+1)'(BURST_LEN));
  assign emit_new  = burst_end && ((new_x != '0) || (new_y != '0));
  assign nres = 2'(emit_old) + 2'(!motion_hit) + 2'(emit_new);

  // Candidate result events
  always_comb begin
    old_ev  = '{ev_type: move_code_r, ev_code: '0, ev_value: sum_x_r,
                ev_extra: sum_y_r, ev_time: mtime_r, last: 1'b0};
    pass_ev = '{ev_type: in_type_r, ev_code: in_code_r, ev_value: in_value_r,
                ev_extra: in_extra_r, ev_time: in_time_r, last: 1'b0};
    new_ev  = '{ev_type: move_code_r, ev_code: '0, ev_value: new_x,
                ev_extra: new_y, ev_time: in_time_r, last: 1'b0};
    res0 = emit_old ? old_ev : (!motion_hit ? pass_ev : new_ev);
    res1 = (emit_old && !motion_hit) ? pass_ev : new_ev;
    res0.last = (nres == 2'd1);
    res1.last = 1'b1;
  end

  // Handshake: process when the queue has room for all results
  assign pop       = out_tvalid && out_tready;
  assign free      = 2'd2 - cnt_r + 2'(pop);
  assign proc      = inv_r && (nres <= free);
  assign in_tready = !inv_r || proc;

  // State update
  always_comb begin
    sum_x_nxt = sum_x_r;
    sum_y_nxt = sum_y_r;
    mtime_nxt = mtime_r;
    burst_nxt = burst_r;
    if (proc) begin
      sum_x_nxt = emit_new ? '0 : new_x;
      sum_y_nxt = emit_new ? '0 : new_y;
      if (motion_hit) mtime_nxt = in_time_r;
      burst_nxt = burst_end ? '0 : burst_inc[CountW-1:0];
    end
  end

  // Result queue: pop head, then push up to two entries
  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (pop) begin
      q_nxt[0] = q_r[1];
      cnt_nxt  = cnt_r - 2'd1;
    end
    base = cnt_nxt;
    if (proc) begin
      case (base)
        2'd0: begin
          q_nxt[0] = res0;
          q_nxt[1] = res1;
        end
        2'd1:    q_nxt[1] = res0;
        default: ;
      endcase
      cnt_nxt = cnt_nxt + nres;
    end
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r   <= 1'b0;
      cnt_r   <= '0;
      sum_x_r <= '0;
      sum_y_r <= '0;
      mtime_r <= '0;
      burst_r <= '0;
    end else begin
      if (in_tready) inv_r <= in_tvalid;
      cnt_r   <= cnt_nxt;
      sum_x_r <= sum_x_nxt;
      sum_y_r <= sum_y_nxt;
      mtime_r <= mtime_nxt;
      burst_r <= burst_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (in_tready && in_tvalid) begin
      in_type_r   <= in_tdata[15:0];
      in_code_r   <= in_tdata[31:16];
      in_value_r  <= $signed(in_tdata[63:32]);
      in_extra_r  <= in_tdata[95:64];
      in_time_r   <= in_tdata[159:96];
      in_qempty_r <= in_tlast;
    end
  end

  // Output port
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {q_r[0].ev_time, q_r[0].ev_extra, q_r[0].ev_value,
                       q_r[0].ev_code, q_r[0].ev_type};
  assign out_tlast  = q_r[0].last;

endmodule
